>>> rtl/dwpid_pkg.sv
// Package for the dual-wheel PID speed controller.
// Holds the configuration register type, register indexes and the fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dwpid_pkg;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 8;

    // Register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_LEFT_TARGET  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RIGHT_TARGET = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_PROP    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_INTEG   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_DERIV   = 3'd4;

    localparam logic [7:0] GAIN_PROP_RST  = 8'd12;
    localparam logic [7:0] GAIN_INTEG_RST = 8'd6;
    localparam logic [7:0] GAIN_DERIV_RST = 8'd1;

    // Widest count the pulse field is widened to before the low bits are taken
    localparam int PULSE_FIELD_BITS = 16;
    localparam int COUNT_MAX_BITS   = 24;

    // Feedforward and duty mapping
    localparam int FF_BITS     = 12;
    localparam int FF_LOW      = 7;
    localparam int FF_HIGH     = 80;
    localparam int FF_SLOPE    = 7;
    localparam int FF_OFFSET   = 53;
    localparam int DRIVE_SCALE = 10;
    localparam int SAT_LEVEL   = 10000;
    localparam int SAT_DUTY    = 8000;
    localparam int REV_MAX     = 65535;

    localparam int FWD_DUTY_BITS = 14;
    localparam int REV_DUTY_BITS = 16;

    typedef struct packed {
        logic signed [7:0] left_target;
        logic signed [7:0] right_target;
        logic [7:0]        kp;
        logic [7:0]        ki;
        logic [7:0]        kd;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/dwpid_cfg.sv
// Configuration register file for the dual-wheel PID speed controller.
// Depends on dwpid_pkg for the register type, indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module dwpid_cfg
    import dwpid_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_LEFT_TARGET:  cfg_next.left_target  = $signed(cfg_wdata);
                REG_RIGHT_TARGET: cfg_next.right_target = $signed(cfg_wdata);
                REG_GAIN_PROP:    cfg_next.kp           = cfg_wdata;
                REG_GAIN_INTEG:   cfg_next.ki           = cfg_wdata;
                REG_GAIN_DERIV:   cfg_next.kd           = cfg_wdata;
                default:          cfg_next              = cfg_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_target  <= '0;
            cfg_reg.right_target <= '0;
            cfg_reg.kp           <= GAIN_PROP_RST;
            cfg_reg.ki           <= GAIN_INTEG_RST;
            cfg_reg.kd           <= GAIN_DERIV_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/dual_wheel_pid_speed_control.sv
// Dual-wheel PID speed controller: incremental-form PID terms plus feedforward.
// Depends on dwpid_pkg and dwpid_cfg.
//
// Each accepted transaction is one sample tick; ticks alternate left wheel (first
// after reset) and right wheel. The block takes one transaction per clock while
// the output is not stalled and presents one result per transaction. The
// datapath is a five-register pipeline: input, error update, gain products,
// term sum, duty mapping. A wheel's error history is updated in the error
// stage, so each tick sees the history of its wheel's previous tick at full
// rate. Backpressure on the output stalls a stage only when that stage is full
// and the stage after it cannot load. Configuration is written through a plain
// write port and should change only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dual_wheel_pid_speed_control
    import dwpid_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [23:0]              s_axis_tdata,  // [15:0] pulse_count, [16] direction_level
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // [13:0] forward_duty, [29:14] reverse_duty
    output logic                          m_axis_tuser,  // [0] wheel_served
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int EW  = COUNT_BITS + 2;   // error
    localparam int D1W = COUNT_BITS + 3;   // first difference
    localparam int D2W = COUNT_BITS + 4;   // second difference
    localparam int PW  = D2W + 9;          // gain product
    localparam int SW  = PW + 2;           // sum of terms
    localparam int VW  = SW + 4;           // scaled drive

    cfg_t cfg;

    dwpid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Stage enables: a stage loads when it is empty or the one after it loads
    logic en_out, en4, en3, en2, en1;
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;

    assign en_out = !vo_reg || m_axis_tready;
    assign en4    = !v4_reg || en_out;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    assign s_axis_tready = en1;

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Stage 1: input register
    logic                          serving_right_reg;
    logic [PULSE_FIELD_BITS-1:0]   s1_pulse_reg;
    logic                          s1_level_reg;
    logic                          s1_wheel_reg;

    // Error history
    logic signed [EW-1:0] left_e1_reg, left_e2_reg, right_e1_reg, right_e2_reg;

    // Stage 1 combinational: speed, error, differences, feedforward
    logic [COUNT_MAX_BITS-1:0] cnt_ext;
    logic [COUNT_BITS-1:0]     count;
    logic                      fwd;
    logic signed [COUNT_BITS:0] speed;
    logic signed [7:0]         target;
    logic signed [EW-1:0]      e0, e1, e2;
    logic signed [D1W-1:0]     d1;
    logic signed [D2W-1:0]     d2;
    logic signed [FF_BITS-1:0] ff_base, ff;
    logic                      tgt_low;

    always_comb
    begin
        cnt_ext = COUNT_MAX_BITS'(s1_pulse_reg);
        count   = cnt_ext[COUNT_BITS-1:0];
        fwd     = s1_wheel_reg ? !s1_level_reg : s1_level_reg;
        speed   = fwd ? $signed({1'b0, count}) : -$signed({1'b0, count});
        target  = s1_wheel_reg ? cfg.right_target : cfg.left_target;
        e1      = s1_wheel_reg ? right_e1_reg : left_e1_reg;
        e2      = s1_wheel_reg ? right_e2_reg : left_e2_reg;
        e0      = EW'(target) - EW'(speed);
        d1      = D1W'(e0) - D1W'(e1);
        d2      = D2W'(e0) - (D2W'(e1) <<< 1) + D2W'(e2);
        ff_base = FF_BITS'(target) * FF_BITS'(FF_SLOPE);
        if (target >= FF_LOW && target <= FF_HIGH)
            ff = ff_base + FF_BITS'(FF_OFFSET);
        else if (target >= -FF_HIGH && target <= -FF_LOW)
            ff = ff_base - FF_BITS'(FF_OFFSET);
        else
            ff = '0;
        tgt_low = target < FF_LOW;
    end

    // Stage 2 registers
    logic signed [D1W-1:0]     s2_d1_reg;
    logic signed [D2W-1:0]     s2_d2_reg;
    logic signed [EW-1:0]      s2_e0_reg;
    logic signed [FF_BITS-1:0] s2_ff_reg;
    logic                      s2_low_reg;
    logic                      s2_wheel_reg;

    // Stage 3: gain products
    logic signed [PW-1:0] p_next, i_next, d_next;
    logic signed [PW-1:0] s3_p_reg, s3_i_reg, s3_d_reg;
    logic signed [FF_BITS-1:0] s3_ff_reg;
    logic                 s3_low_reg;
    logic                 s3_wheel_reg;

    always_comb
    begin
        p_next = PW'($signed({1'b0, cfg.kp})) * PW'(s2_d1_reg);
        i_next = PW'($signed({1'b0, cfg.ki})) * PW'(s2_e0_reg);
        d_next = PW'($signed({1'b0, cfg.kd})) * PW'(s2_d2_reg);
    end

    // Stage 4: sum of terms
    logic signed [SW-1:0] sum_next, s4_sum_reg;
    logic                 s4_low_reg;
    logic                 s4_wheel_reg;

    assign sum_next = SW'(s3_p_reg) + SW'(s3_i_reg) + SW'(s3_d_reg) + SW'(s3_ff_reg);

    // Output stage: scale and map to duties
    logic signed [VW-1:0]       v, mag;
    logic [FWD_DUTY_BITS-1:0]   fduty_next, fduty_reg;
    logic [REV_DUTY_BITS-1:0]   rduty_next, rduty_reg;
    logic                       wheel_out_reg;

    always_comb
    begin
        v          = VW'(s4_sum_reg) * VW'(DRIVE_SCALE);
        mag        = -v;
        fduty_next = '0;
        rduty_next = '0;
        if (v >= VW'(SAT_LEVEL))
            fduty_next = FWD_DUTY_BITS'(SAT_DUTY);
        else if (v < 0)
        begin
            if (s4_low_reg)
            begin
                if (mag > VW'(REV_MAX))
                    rduty_next = REV_DUTY_BITS'(REV_MAX);
                else
                    rduty_next = mag[REV_DUTY_BITS-1:0];
            end
        end
        else
            fduty_next = v[FWD_DUTY_BITS-1:0];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            v4_reg            <= 1'b0;
            vo_reg            <= 1'b0;
            serving_right_reg <= 1'b0;
            left_e1_reg       <= '0;
            left_e2_reg       <= '0;
            right_e1_reg      <= '0;
            right_e2_reg      <= '0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en_out)
                vo_reg <= v4_reg;
            if (in_xfer)
                serving_right_reg <= !serving_right_reg;
            // Advance the served wheel's error history as its tick leaves stage 1
            if (v1_reg && en2)
            begin
                if (s1_wheel_reg)
                begin
                    right_e2_reg <= right_e1_reg;
                    right_e1_reg <= e0;
                end
                else
                begin
                    left_e2_reg <= left_e1_reg;
                    left_e1_reg <= e0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pulse_reg <= s_axis_tdata[PULSE_FIELD_BITS-1:0];
            s1_level_reg <= s_axis_tdata[PULSE_FIELD_BITS];
            s1_wheel_reg <= serving_right_reg;
        end
        if (en2)
        begin
            s2_d1_reg    <= d1;
            s2_d2_reg    <= d2;
            s2_e0_reg    <= e0;
            s2_ff_reg    <= ff;
            s2_low_reg   <= tgt_low;
            s2_wheel_reg <= s1_wheel_reg;
        end
        if (en3)
        begin
            s3_p_reg     <= p_next;
            s3_i_reg     <= i_next;
            s3_d_reg     <= d_next;
            s3_ff_reg    <= s2_ff_reg;
            s3_low_reg   <= s2_low_reg;
            s3_wheel_reg <= s2_wheel_reg;
        end
        if (en4)
        begin
            s4_sum_reg   <= sum_next;
            s4_low_reg   <= s3_low_reg;
            s4_wheel_reg <= s3_wheel_reg;
        end
        if (en_out)
        begin
            fduty_reg     <= fduty_next;
            rduty_reg     <= rduty_next;
            wheel_out_reg <= s4_wheel_reg;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {2'b00, rduty_reg, fduty_reg};
    assign m_axis_tuser  = wheel_out_reg;

`ifndef SYNTHESIS
    a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:0] < 14'd10000))
        else $error("forward duty out of range");

    a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:0] == '0 || m_axis_tdata[29:14] == '0))
        else $error("both drive channels active");

    a_wheel_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (serving_right_reg != $past(serving_right_reg)))
        else $error("served wheel did not alternate");

    a_hist_alt: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && en2 && v2_reg && en3) |=> (s2_wheel_reg != $past(s2_wheel_reg)))
        else $error("consecutive ticks served the same wheel");
`endif

endmodule

`default_nettype wire
